[sv/llpm_pkg.sv]
// Shared types, constants and helpers of the luma and palette pixel mapper.
package llpm_pkg;

  localparam int unsigned AddrW    = 8;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned CountW   = 9;
  localparam int unsigned ProdW    = 24;
  localparam int unsigned TblDepth = 1 << AddrW;

  localparam logic [CountW-1:0] CountMax  = CountW'(TblDepth);
  localparam logic [15:0]       LumaWr    = 16'd19595;
  localparam logic [15:0]       LumaWg    = 16'd38470;
  localparam logic [15:0]       LumaWb    = 16'd7471;
  localparam logic [ProdW-1:0]  LumaHalf  = ProdW'(32768);
  localparam logic [7:0]        AlphaOpaque = 8'hFF;

  typedef enum logic {
    ActConvert  = 1'b0,
    ActTblWrite = 1'b1
  } action_e;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] data;
  } tbl_wr_t;

  function automatic logic [ColorW-1:0] ramp_value(input logic [AddrW-1:0] idx);
    ramp_value = {idx, idx, idx};
  endfunction

endpackage

[sv/llpm_table.sv]
// Colour table memory with per-entry valid bits; an unwritten entry reads as the gray ramp.
module llpm_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [llpm_pkg::AddrW-1:0]  rd_addr_i,
  input  llpm_pkg::tbl_wr_t        wr_i,
  output logic [llpm_pkg::ColorW-1:0] rd_data_o
);
  import llpm_pkg::*;

  logic [ColorW-1:0] mem [TblDepth];
  logic [ColorW-1:0] rdata_q;
  logic [AddrW-1:0]  addr_q;
  logic [TblDepth-1:0] ent_vld_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      addr_q  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        ent_vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= ent_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rdata_q : ramp_value(addr_q);

endmodule

[sv/luma_lut_pixel_mapper_core.sv]
// Luma and palette pixel mapper: 8-bit palette or RGB pixels to opaque ARGB through a 256-entry colour table.
// A request passes the s1 stage (luma products), the s2 stage (table read) and the output register.
// Throughput: one request per cycle, pixels and table writes alike, unless out_stall_i holds the
// pipeline; table read, compare and write back overlap, with forwarding from the write-back stage.
// Reset: table reads as the gray ramp through per-entry valid bits, no clearing pass;
// mismatch count and multi_q clear to zero.
module luma_lut_pixel_mapper_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [7:0]                 first_byte_i,
  input  logic [7:0]                 second_byte_i,
  input  logic [7:0]                 third_byte_i,
  input  logic [llpm_pkg::AddrW-1:0]  table_index_i,
  input  logic [llpm_pkg::ColorW-1:0] table_color_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                pixel_argb_o
);
  import llpm_pkg::*;

  logic              multi_q;
  logic [CountW-1:0] count_q, count_d;

  logic              s1_vld_q, s1_act_q;
  logic [7:0]        s1_r_q, s1_g_q, s1_b_q;
  logic [AddrW-1:0]  s1_idx_q;
  logic [ColorW-1:0] s1_col_q;
  logic [ProdW-1:0]  s1_pr_q, s1_pg_q, s1_pb_q;

  logic              s2_vld_q, s2_act_q, s2_fwd_q;
  logic [7:0]        s2_r_q, s2_g_q, s2_b_q;
  logic [AddrW-1:0]  s2_addr_q;
  logic [ColorW-1:0] s2_col_q, s2_fcol_q;

  logic              out_vld_q;
  logic [31:0]       out_pix_q;

  logic              s1_adv, s2_adv, out_adv, accept, commit, fwd_d, was_off, now_off;
  logic [ProdW-1:0]  luma_sum;
  logic [AddrW-1:0]  rd_addr;
  logic [ColorW-1:0] rd_data, old_col, pix_col;
  tbl_wr_t           tbl_wr;

  assign out_adv = !out_vld_q || !out_stall_i;
  assign s2_adv  = !s2_vld_q || (s2_act_q == ActTblWrite) || out_adv;
  assign s1_adv  = !s1_vld_q || s2_adv;
  assign accept  = in_valid_i && s1_adv;
  assign in_stall_o = !s1_adv;

  assign luma_sum = s1_pr_q + s1_pg_q + s1_pb_q + LumaHalf;
  assign rd_addr  = (s1_act_q == ActTblWrite) ? s1_idx_q
                  : (multi_q ? luma_sum[ProdW-1 -: AddrW] : s1_r_q);

  assign commit = s2_vld_q && (s2_act_q == ActTblWrite);
  assign fwd_d  = commit && (s2_addr_q == rd_addr);

  assign tbl_wr.en   = commit;
  assign tbl_wr.addr = s2_addr_q;
  assign tbl_wr.data = s2_col_q;

  llpm_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s2_adv),
    .rd_addr_i (rd_addr),
    .wr_i      (tbl_wr),
    .rd_data_o (rd_data)
  );

  assign old_col = s2_fwd_q ? s2_fcol_q : rd_data;
  assign was_off = old_col != ramp_value(s2_addr_q);
  assign now_off = s2_col_q != ramp_value(s2_addr_q);
  assign pix_col = (multi_q && (count_q == '0)) ? {s2_r_q, s2_g_q, s2_b_q} : old_col;

  always_comb begin
    count_d = count_q;
    if (commit) begin
      if (was_off && !now_off && (count_q != '0)) begin
        count_d = count_q - CountW'(1);
      end else if (!was_off && now_off && (count_q < CountMax)) begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multi_q   <= 1'b0;
      count_q   <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        multi_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (s1_adv) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_vld_q <= s1_vld_q;
      end
      if (out_adv) begin
        out_vld_q <= s2_vld_q && (s2_act_q == ActConvert);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q <= action_i;
      s1_r_q   <= first_byte_i;
      s1_g_q   <= second_byte_i;
      s1_b_q   <= third_byte_i;
      s1_idx_q <= table_index_i;
      s1_col_q <= table_color_i;
      s1_pr_q  <= ProdW'(LumaWr) * ProdW'(first_byte_i);
      s1_pg_q  <= ProdW'(LumaWg) * ProdW'(second_byte_i);
      s1_pb_q  <= ProdW'(LumaWb) * ProdW'(third_byte_i);
    end
    if (s2_adv) begin
      s2_act_q  <= s1_act_q;
      s2_r_q    <= s1_r_q;
      s2_g_q    <= s1_g_q;
      s2_b_q    <= s1_b_q;
      s2_addr_q <= rd_addr;
      s2_col_q  <= s1_col_q;
      s2_fwd_q  <= fwd_d;
      s2_fcol_q <= s2_col_q;
    end
    if (out_adv && s2_vld_q && (s2_act_q == ActConvert)) begin
      out_pix_q <= {AlphaOpaque, pix_col};
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pixel_argb_o = out_pix_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("mismatch count beyond table depth");

  a_stall_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && s2_vld_q))
    else $error("input stalled with a free stage");

  a_pixel_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && (s2_act_q == ActConvert) && s2_adv) |=> out_vld_q)
    else $error("converted pixel lost");

  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && out_vld_q && out_stall_i) |=> !$rose(out_vld_q) && out_vld_q)
    else $error("table write produced a result");

endmodule

[tb/llpm_pixel_checker.sv]
// Checker for the pixel mapper: predicts each ARGB result and compares it with the DUT output.
module llpm_pixel_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        action_i,
  input  logic [7:0]                  first_byte_i,
  input  logic [7:0]                  second_byte_i,
  input  logic [7:0]                  third_byte_i,
  input  logic [llpm_pkg::AddrW-1:0]  table_index_i,
  input  logic [llpm_pkg::ColorW-1:0] table_color_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [31:0]                 pixel_argb_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import llpm_pkg::*;

  logic [ColorW-1:0] color_lut [TblDepth];
  int                off_ramp_count;
  logic              multi_mode;
  logic [31:0]       expected_argb_q [$];
  int                fail_count = 0;
  int                pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic logic [31:0] map_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [31:0] luma;
    logic [7:0]  sel;
    if (multi_mode && off_ramp_count == 0) begin
      return {AlphaOpaque, r, g, b};
    end
    if (multi_mode) begin
      luma = (32'(LumaWr) * r + 32'(LumaWg) * g + 32'(LumaWb) * b + 32'(LumaHalf)) >> 16;
      sel  = luma[7:0];
    end else begin
      sel = r;
    end
    return {AlphaOpaque, color_lut[sel]};
  endfunction

  task automatic write_entry(logic [AddrW-1:0] idx, logic [ColorW-1:0] col);
    bit was_off;
    bit now_off;
    was_off = color_lut[idx] != {3{idx}};
    now_off = col != {3{idx}};
    if (was_off && !now_off && off_ramp_count > 0) begin
      off_ramp_count--;
    end else if (!was_off && now_off && off_ramp_count < TblDepth) begin
      off_ramp_count++;
    end
    color_lut[idx] = col;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s: pixel_argb %08h, expected %08h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TblDepth; i++) begin
        color_lut[i] = {3{i[7:0]}};
      end
      off_ramp_count = 0;
      multi_mode     = 1'b0;
      expected_argb_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_argb_q.size() == 0) begin
          report_mismatch("result with no request pending", pixel_argb_i, 32'h0);
        end else begin
          if (pixel_argb_i !== expected_argb_q[0]) begin
            report_mismatch("wrong pixel", pixel_argb_i, expected_argb_q[0]);
          end
          void'(expected_argb_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        multi_mode = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ActTblWrite) begin
          write_entry(table_index_i, table_color_i);
        end else begin
          expected_argb_q.push_back(map_pixel(first_byte_i, second_byte_i, third_byte_i));
        end
      end
      pending = expected_argb_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the pixel mapper: clock, reset, request stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import llpm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 270;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              action_i;
  logic [7:0]        first_byte_i;
  logic [7:0]        second_byte_i;
  logic [7:0]        third_byte_i;
  logic [AddrW-1:0]  table_index_i;
  logic [ColorW-1:0] table_color_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [31:0]       pixel_argb_o;

  int                fail_count;
  int                pending;
  int                cycles = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  bit                dirty_entry [TblDepth];
  logic [AddrW-1:0]  hot_index [4];

  luma_lut_pixel_mapper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .third_byte_i  (third_byte_i),
    .table_index_i (table_index_i),
    .table_color_i (table_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_argb_o  (pixel_argb_o)
  );

  llpm_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .action_i      (action_i),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .third_byte_i  (third_byte_i),
    .table_index_i (table_index_i),
    .table_color_i (table_color_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_argb_i  (pixel_argb_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_req(action_e act, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                          logic [AddrW-1:0] idx, logic [ColorW-1:0] col);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    first_byte_i  <= b0;
    second_byte_i <= b1;
    third_byte_i  <= b2;
    table_index_i <= idx;
    table_color_i <= col;
    if (act == ActTblWrite) begin
      dirty_entry[idx] = col != {3{idx}};
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_req(ActConvert, r, g, b, AddrW'($urandom), ColorW'($urandom));
  endtask

  task automatic send_write(logic [AddrW-1:0] idx, logic [ColorW-1:0] col);
    send_req(ActTblWrite, 8'($urandom), 8'($urandom), 8'($urandom), idx, col);
  endtask

  task automatic set_mode(logic multi);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= multi;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic restore_ramp();
    for (int i = 0; i < TblDepth; i++) begin
      if (dirty_entry[i]) begin
        send_write(AddrW'(i), {3{i[7:0]}});
      end
    end
  endtask

  task automatic random_phase(int n);
    logic [AddrW-1:0]  idx;
    logic [ColorW-1:0] col;
    logic [7:0]        r;
    for (int k = 0; k < n; k++) begin
      if (k > 0 && k % 70 == 0) begin
        restore_ramp();
      end
      if ($urandom_range(99) < 18) begin
        idx = ($urandom_range(99) < 75) ? hot_index[$urandom_range(3)]
                                        : AddrW'($urandom_range(255));
        col = ($urandom_range(99) < 45) ? {3{idx}} : ColorW'($urandom);
        send_write(idx, col);
      end else begin
        r = ($urandom_range(99) < 35) ? hot_index[$urandom_range(3)] : 8'($urandom);
        if ($urandom_range(99) < 30) begin
          send_pixel(r, r, r);
        end else begin
          send_pixel(r, 8'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];
    phase_idle  = '{0, 67, 0, 28};
    phase_stall = '{0, 0, 67, 28};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ActConvert;
    first_byte_i  = '0;
    second_byte_i = '0;
    third_byte_i  = '0;
    table_index_i = '0;
    table_color_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // gray mode on the reset ramp
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    set_mode(1'b1);
    // pass-through while the table is the ramp
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h7F);
    send_write(8'h00, 24'h000000);
    send_pixel(8'h12, 8'h34, 8'h56);
    // luma lookup once an entry leaves the ramp
    send_write(8'h80, 24'hFFFFFF);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_write(8'h80, 24'h808080);
    send_pixel(8'h0A, 8'h14, 8'h1E);
    send_write(8'hFF, 24'h000000);
    send_write(8'hFF, 24'h123456);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    set_mode(1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h80, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h55, 8'hAA);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = 0;
      stall_pct = 0;
      restore_ramp();
      set_mode((p == 3) ? 1'($urandom_range(1)) : ((p % 2) == 0));
      for (int j = 0; j < 4; j++) begin
        hot_index[j] = AddrW'($urandom_range(255));
      end
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      random_phase(PhaseItems);
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
